/* rtl/core/first_fit_free_list_allocator_core_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the first-fit free-list allocator core.
// Each macro expects signals named clk and rst in the including scope.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_FREE_LIST_ALLOCATOR_CORE_ASSERT_SVH
`define FIRST_FIT_FREE_LIST_ALLOCATOR_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FFA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FFA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/ffa_pkg.sv */
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package ffa_pkg;

  // Default memory depth in words and reset value of the heap length register.
  localparam int MEM_WORDS_DEF = 4096;
  localparam logic [15:0] HEAP_WORDS_RST = 16'd4096;

  // Link value that ends the free list.
  localparam logic [15:0] END_LINK = 16'hFFFF;

  // Request kinds.
  localparam logic [1:0] KIND_FORMAT = 2'd0;
  localparam logic [1:0] KIND_ALLOC  = 2'd1;
  localparam logic [1:0] KIND_FREE   = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOMEM  = 2'd1;
  localparam logic [1:0] ST_REJECT = 2'd2;

  // Memory write selection.
  typedef enum logic [2:0] {
    WR_NONE   = 3'd0,
    WR_FMT0   = 3'd1,
    WR_FMT1   = 3'd2,
    WR_FREE0  = 3'd3,
    WR_FREE1  = 3'd4,
    WR_SHRINK = 3'd5,
    WR_UNLINK = 3'd6
  } wr_sel_t;

  // Free list head update selection.
  typedef enum logic [2:0] {
    HD_KEEP  = 3'd0,
    HD_FMT   = 3'd1,
    HD_EMPTY = 3'd2,
    HD_FREE  = 3'd3,
    HD_NEXT  = 3'd4
  } head_sel_t;

  // Granted address selection.
  typedef enum logic [1:0] {
    GR_ZERO = 2'd0,
    GR_TAIL = 2'd1,
    GR_CUR  = 2'd2
  } grant_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       latch;
    logic       init_walk;
    logic       rd_cur;
    logic       rd_link;
    logic       step;
    logic       count;
    logic       capture;
    logic       res_load;
    wr_sel_t    wr_sel;
    head_sel_t  head_sel;
    grant_sel_t grant_sel;
    logic [1:0] res_status;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] kind;
    logic       words_zero;
    logic       fmt_ok;
    logic       free_ok;
    logic       walk_go;
    logic       fit_split;
    logic       fit_whole;
    logic       prev_valid;
  } stat_t;

endpackage

`default_nettype wire

/* rtl/core/ffa_ctrl.sv */
// ----------------------------------------------------------------------------
// ffa_ctrl
// Controller state machine: sequences format, free and the first-fit walk,
// and owns the request and result handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module ffa_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  input  wire ffa_pkg::stat_t stat,
  output ffa_pkg::cmd_t      cmd
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_DECODE = 9'b000000010,
    S_FMT1   = 9'b000000100,
    S_FREE1  = 9'b000001000,
    S_WALK   = 9'b000010000,
    S_SIZE   = 9'b000100000,
    S_FIT    = 9'b001000000,
    S_LINK   = 9'b010000000,
    S_RESULT = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  // The result register can take a new value when empty or being drained.
  assign out_free  = !rsp_valid || !rsp_stall;
  assign req_stall = (state != S_IDLE);

  // Next state and command decode.
  always_comb begin
    state_next    = state;
    cmd           = '0;
    cmd.wr_sel    = ffa_pkg::WR_NONE;
    cmd.head_sel  = ffa_pkg::HD_KEEP;
    cmd.grant_sel = ffa_pkg::GR_ZERO;
    cmd.res_status = ffa_pkg::ST_REJECT;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat.kind)
          ffa_pkg::KIND_FORMAT: begin
            if (stat.fmt_ok) begin
              cmd.wr_sel = ffa_pkg::WR_FMT0;
              state_next = S_FMT1;
            end else begin
              cmd.head_sel = ffa_pkg::HD_EMPTY;
              cmd.capture  = 1'b1;
              state_next   = S_RESULT;
            end
          end
          ffa_pkg::KIND_ALLOC: begin
            if (stat.words_zero) begin
              cmd.capture = 1'b1;
              state_next  = S_RESULT;
            end else begin
              cmd.init_walk = 1'b1;
              state_next    = S_WALK;
            end
          end
          ffa_pkg::KIND_FREE: begin
            if (stat.free_ok) begin
              cmd.wr_sel = ffa_pkg::WR_FREE0;
              state_next = S_FREE1;
            end else begin
              cmd.capture = 1'b1;
              state_next  = S_RESULT;
            end
          end
          default: begin
            // Unknown kind is rejected without touching the heap.
            cmd.capture = 1'b1;
            state_next  = S_RESULT;
          end
        endcase
      end
      S_FMT1: begin
        cmd.wr_sel     = ffa_pkg::WR_FMT1;
        cmd.head_sel   = ffa_pkg::HD_FMT;
        cmd.capture    = 1'b1;
        cmd.res_status = ffa_pkg::ST_OK;
        state_next     = S_RESULT;
      end
      S_FREE1: begin
        cmd.wr_sel     = ffa_pkg::WR_FREE1;
        cmd.head_sel   = ffa_pkg::HD_FREE;
        cmd.capture    = 1'b1;
        cmd.res_status = ffa_pkg::ST_OK;
        state_next     = S_RESULT;
      end
      S_WALK: begin
        if (stat.walk_go) begin
          cmd.rd_cur = 1'b1;
          state_next = S_SIZE;
        end else begin
          cmd.capture    = 1'b1;
          cmd.res_status = ffa_pkg::ST_NOMEM;
          state_next     = S_RESULT;
        end
      end
      S_SIZE: begin
        cmd.count = 1'b1;
        if (stat.fit_split) begin
          cmd.wr_sel     = ffa_pkg::WR_SHRINK;
          cmd.capture    = 1'b1;
          cmd.grant_sel  = ffa_pkg::GR_TAIL;
          cmd.res_status = ffa_pkg::ST_OK;
          state_next     = S_RESULT;
        end else begin
          cmd.rd_link = 1'b1;
          state_next  = stat.fit_whole ? S_FIT : S_LINK;
        end
      end
      S_FIT: begin
        // Unlink the whole block from its predecessor or from the head.
        if (stat.prev_valid) begin
          cmd.wr_sel = ffa_pkg::WR_UNLINK;
        end else begin
          cmd.head_sel = ffa_pkg::HD_NEXT;
        end
        cmd.capture    = 1'b1;
        cmd.grant_sel  = ffa_pkg::GR_CUR;
        cmd.res_status = ffa_pkg::ST_OK;
        state_next     = S_RESULT;
      end
      S_LINK: begin
        cmd.step   = 1'b1;
        state_next = S_WALK;
      end
      S_RESULT: begin
        if (out_free) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.res_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/ffa_datapath.sv */
// ----------------------------------------------------------------------------
// ffa_datapath
// Heap memory, free list head, walk pointers, length register and result
// registers of the allocator.
// ----------------------------------------------------------------------------
`default_nettype none

module ffa_datapath #(
  parameter int MEM_WORDS = ffa_pkg::MEM_WORDS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_we,
  input  wire logic [15:0]   cfg_data,
  input  wire logic [1:0]    kind,
  input  wire logic [15:0]   block_words,
  input  wire logic [15:0]   block_address,
  input  wire ffa_pkg::cmd_t cmd,
  output ffa_pkg::stat_t     stat,
  output logic [1:0]         status,
  output logic [15:0]        granted_address
);

  localparam int AW = $clog2(MEM_WORDS);
  localparam int VW = $clog2(MEM_WORDS + 1);
  localparam logic [15:0] MEM_LIM = 16'(MEM_WORDS);
  localparam logic [VW-1:0] VISIT_MAX = VW'(MEM_WORDS);

  logic [15:0]   mem [MEM_WORDS];
  logic [15:0]   heap_words;
  logic [15:0]   free_head;
  logic [1:0]    req_kind;
  logic [15:0]   req_words;
  logic [15:0]   req_addr;
  logic [15:0]   cur;
  logic [15:0]   prev;
  logic          prev_valid;
  logic [VW-1:0] visits;
  logic [15:0]   rd_data;
  logic [1:0]    pend_status;
  logic [15:0]   pend_grant;

  logic [15:0] lim;
  logic [15:0] cur_link;
  logic [15:0] left;
  logic [15:0] tail;
  logic [15:0] rd_addr;
  logic        wr_en;
  logic [15:0] wr_addr;
  logic [15:0] wr_data;
  logic [15:0] grant_next;

  // Effective heap length, clamped to the memory depth.
  assign lim      = (heap_words > MEM_LIM) ? MEM_LIM : heap_words;
  assign cur_link = 16'(cur + 16'd1);
  assign left     = 16'(rd_data - req_words);
  assign tail     = 16'(cur + left);

  // Status toward the controller.
  always_comb begin
    stat.kind       = req_kind;
    stat.words_zero = (req_words == 16'd0);
    stat.fmt_ok     = (lim >= 16'd2);
    stat.free_ok    = (req_words >= 16'd2) &&
                      (({1'b0, req_addr} + {1'b0, req_words}) <= {1'b0, lim});
    stat.walk_go    = (cur != ffa_pkg::END_LINK) &&
                      (({1'b0, cur} + 17'd1) < {1'b0, lim}) &&
                      (visits < VISIT_MAX);
    stat.fit_split  = ({1'b0, rd_data} >= ({1'b0, req_words} + 17'd2));
    stat.fit_whole  = (rd_data >= req_words);
    stat.prev_valid = prev_valid;
  end

  // Memory write port selection.
  always_comb begin
    wr_en   = 1'b1;
    wr_addr = 16'd0;
    wr_data = 16'd0;
    unique case (cmd.wr_sel)
      ffa_pkg::WR_NONE: begin
        wr_en = 1'b0;
      end
      ffa_pkg::WR_FMT0: begin
        wr_addr = 16'd0;
        wr_data = lim;
      end
      ffa_pkg::WR_FMT1: begin
        wr_addr = 16'd1;
        wr_data = ffa_pkg::END_LINK;
      end
      ffa_pkg::WR_FREE0: begin
        wr_addr = req_addr;
        wr_data = req_words;
      end
      ffa_pkg::WR_FREE1: begin
        wr_addr = 16'(req_addr + 16'd1);
        wr_data = free_head;
      end
      ffa_pkg::WR_SHRINK: begin
        wr_addr = cur;
        wr_data = left;
      end
      ffa_pkg::WR_UNLINK: begin
        wr_addr = 16'(prev + 16'd1);
        wr_data = rd_data;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  assign rd_addr = cmd.rd_link ? cur_link : cur;

  // Heap memory with one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr[AW-1:0]] <= wr_data;
    end
    if (cmd.rd_cur || cmd.rd_link) begin
      rd_data <= mem[rd_addr[AW-1:0]];
    end
  end

  // Heap length register and free list head.
  always_ff @(posedge clk) begin
    if (rst) begin
      heap_words <= ffa_pkg::HEAP_WORDS_RST;
      free_head  <= ffa_pkg::END_LINK;
    end else begin
      if (cfg_we) begin
        heap_words <= cfg_data;
      end
      unique case (cmd.head_sel)
        ffa_pkg::HD_KEEP:  free_head <= free_head;
        ffa_pkg::HD_FMT:   free_head <= 16'd0;
        ffa_pkg::HD_EMPTY: free_head <= ffa_pkg::END_LINK;
        ffa_pkg::HD_FREE:  free_head <= req_addr;
        ffa_pkg::HD_NEXT:  free_head <= rd_data;
        default:           free_head <= free_head;
      endcase
    end
  end

  // Request fields captured when a transaction is accepted.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_kind  <= kind;
      req_words <= block_words;
      req_addr  <= block_address;
    end
  end

  // Walk pointers and visit counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_valid <= 1'b0;
      visits     <= '0;
    end else if (cmd.init_walk) begin
      prev_valid <= 1'b0;
      visits     <= '0;
    end else begin
      if (cmd.step) begin
        prev_valid <= 1'b1;
      end
      if (cmd.count) begin
        visits <= VW'(visits + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init_walk) begin
      cur <= free_head;
    end else if (cmd.step) begin
      prev <= cur;
      cur  <= rd_data;
    end
  end

  // Granted address source.
  always_comb begin
    unique case (cmd.grant_sel)
      ffa_pkg::GR_ZERO: grant_next = 16'd0;
      ffa_pkg::GR_TAIL: grant_next = tail;
      ffa_pkg::GR_CUR:  grant_next = cur;
      default:          grant_next = 16'd0;
    endcase
  end

  // Pending result, then the output register.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pend_status <= cmd.res_status;
      pend_grant  <= grant_next;
    end
    if (cmd.res_load) begin
      status          <= pend_status;
      granted_address <= pend_grant;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/first_fit_free_list_allocator_core.sv */
// ----------------------------------------------------------------------------
// first_fit_free_list_allocator_core
// First-fit heap allocator whose free list is linked through the heap memory.
//
//   Channel   Direction  Handshake            Payload
//   request   in         req_valid/req_stall  kind, block_words, block_address
//   result    out        rsp_valid/rsp_stall  status, granted_address
//   config    in         cfg_we               cfg_data (heap length in words)
//
// A format or a free writes two heap words, one per state, before its result
// is captured; a rejected request is captured on decode. An allocate fetches
// size and link of each block it passes over in turn through the one read port.
// Synchronous reset empties the free list; the heap memory is not cleared.
// A result waits in its output register while rsp_stall is high; the next
// request is taken once the result is loaded.
// ----------------------------------------------------------------------------
`default_nettype none

`include "first_fit_free_list_allocator_core_assert.svh"

module first_fit_free_list_allocator_core #(
  parameter int MEM_WORDS = ffa_pkg::MEM_WORDS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_data,
  input  wire logic        req_valid,
  output logic             req_stall,
  input  wire logic [1:0]  kind,
  input  wire logic [15:0] block_words,
  input  wire logic [15:0] block_address,
  output logic             rsp_valid,
  input  wire logic        rsp_stall,
  output logic [1:0]       status,
  output logic [15:0]      granted_address
);

  ffa_pkg::cmd_t  cmd;
  ffa_pkg::stat_t stat;

  // Controller.
  ffa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Datapath.
  ffa_datapath #(
    .MEM_WORDS (MEM_WORDS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data),
    .kind            (kind),
    .block_words     (block_words),
    .block_address   (block_address),
    .cmd             (cmd),
    .stat            (stat),
    .status          (status),
    .granted_address (granted_address)
  );

  // A new transaction is never taken while one is in progress.
  `FFA_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall, "accept while busy")

  // A result is never loaded over one that is still stalled.
  `FFA_ASSERT_NOW(a_no_overwrite, cmd.res_load, !(rsp_valid && rsp_stall), "result overwritten")

  // Only a successful allocate carries a nonzero address.
  `FFA_ASSERT_NOW(a_grant_zero, rsp_valid && (status != ffa_pkg::ST_OK), granted_address == 16'd0, "address on failure")

endmodule

`default_nettype wire
